FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the port-level checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_PROP(lbl, clk, rstn, !(expr), msg)

`endif

FILE: rtl/core/rar_pkg.sv
// ---------------------------------------------------------------------------
// rar_pkg
// Types, constants and helper functions of the rational add/reduce unit.
// ---------------------------------------------------------------------------
package rar_pkg;

    // Datapath width of all intermediate values (8 to 64).
    localparam int WIDTH = 32;
    // Width of the divider step counter; it must hold WIDTH itself.
    localparam int CNT_W = $clog2(WIDTH + 1);

    // Operation codes carried by each request.
    typedef enum logic [1:0] {
        OP_MAKE  = 2'd0,
        OP_ADD   = 2'd1,
        OP_EQUAL = 2'd2,
        OP_NONE  = 2'd3
    } rar_op_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DEN,
        ST_MAKE,
        ST_GCD,
        ST_GCD_WAIT,
        ST_DIVN,
        ST_DIVN_WAIT,
        ST_DIVD,
        ST_DIVD_WAIT,
        ST_DONE
    } rar_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
    } rar_div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] quot;
        logic [WIDTH-1:0] rem;
    } rar_div_rsp_t;

    // Sign-extend or truncate a 32-bit port value to the datapath width.
    function automatic logic [WIDTH-1:0] ext_in(input logic [31:0] v);
        logic signed [63:0] t;
        t = 64'(signed'(v));
        return t[WIDTH-1:0];
    endfunction

    // Sign-extend or truncate a datapath value to a 32-bit port value.
    function automatic logic [31:0] to_out(input logic [WIDTH-1:0] x);
        logic signed [63:0] t;
        t = 64'(signed'(x));
        return t[31:0];
    endfunction

    // Magnitude of a two's complement value as an unsigned value.
    function automatic logic [WIDTH-1:0] mag_w(input logic [WIDTH-1:0] x);
        return x[WIDTH-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

FILE: rtl/core/rar_divu.sv
// ---------------------------------------------------------------------------
// rar_divu
// Shared unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rar_divu import rar_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  rar_div_req_t req,
    output rar_div_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    // Shift in one dividend bit and try to subtract the divisor.
    always_comb begin
        shifted   = {rem_reg, quo_reg[WIDTH-1]};
        trial     = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (busy_reg) begin
            if (!trial[WIDTH]) begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: rtl/core/rational_add_reduce.sv
// Make runs Euclid GCD steps and then divides numerator and denominator by
// the GCD; add first forms the cross products and the denominator product.
// Equals ends with the cross products. All remainders and quotients come from
// one shared divider, one bit per cycle; one request is in work at a time.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// the result valid; no other state is kept between requests.
// ---------------------------------------------------------------------------
// rational_add_reduce
// Rational make/add/equals unit with Euclid GCD reduction, built around a
// shared multiplier and a shared iterative divider.
// ---------------------------------------------------------------------------
module rational_add_reduce import rar_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_a_num,
    input  logic signed [31:0] s_a_den,
    input  logic signed [31:0] s_b_num,
    input  logic signed [31:0] s_b_den,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_num,
    output logic signed [31:0] m_res_den,
    output logic               m_is_equal
);

    rar_state_t       state_reg, state_next;
    rar_op_t          op_reg, op_next;
    logic [WIDTH-1:0] an_reg, an_next;
    logic [WIDTH-1:0] ad_reg, ad_next;
    logic [WIDTH-1:0] bn_reg, bn_next;
    logic [WIDTH-1:0] bd_reg, bd_next;
    logic [WIDTH-1:0] prod_reg, prod_next;
    logic [WIDTH-1:0] x_reg, x_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [WIDTH-1:0] ga_reg, ga_next;
    logic [WIDTH-1:0] gb_reg, gb_next;
    logic [WIDTH-1:0] rn_reg, rn_next;
    logic [WIDTH-1:0] rd_reg, rd_next;
    logic             eq_reg, eq_next;
    logic             mv_reg, mv_next;
    logic [31:0]      on_reg, on_next;
    logic [31:0]      od_reg, od_next;
    logic             oe_reg, oe_next;
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [WIDTH-1:0] nn, dn;
    rar_div_req_t     div_req;
    rar_div_rsp_t     div_rsp;

    // Shared divider for remainders and the final exact divisions.
    rar_divu u_divu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Shared multiplier operand selection; the product is always registered.
    always_comb begin
        unique case (state_reg)
            ST_MUL1: begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
            ST_MUL2: begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default: begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Sequencer: next state, working registers and divider requests.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        x_next     = x_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        eq_next    = eq_reg;
        mv_next    = mv_reg;
        on_next    = on_reg;
        od_next    = od_reg;
        oe_next    = oe_reg;
        div_req    = '0;
        nn         = d_reg[WIDTH-1] ? (~n_reg + 1'b1) : n_reg;
        dn         = d_reg[WIDTH-1] ? (~d_reg + 1'b1) : d_reg;

        // The result register drains independently of the sequencer.
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next = rar_op_t'(s_opcode);
                    an_next = ext_in(s_a_num);
                    ad_next = ext_in(s_a_den);
                    bn_next = ext_in(s_b_num);
                    bd_next = ext_in(s_b_den);
                    n_next  = ext_in(s_a_num);
                    d_next  = ext_in(s_a_den);
                    unique case (rar_op_t'(s_opcode))
                        OP_MAKE:  state_next = ST_MAKE;
                        OP_ADD,
                        OP_EQUAL: state_next = ST_MUL1;
                        OP_NONE: begin
                            rn_next    = '0;
                            rd_next    = '0;
                            eq_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL1: begin
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                // Keep a_num * b_den while b_num * a_den is formed.
                x_next     = prod_reg;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                // Equals ends here with the cross products compared.
                if (op_reg == OP_EQUAL) begin
                    rn_next    = '0;
                    rd_next    = '0;
                    eq_next    = (x_reg == prod_reg);
                    state_next = ST_DONE;
                end else begin
                    n_next     = x_reg + prod_reg;
                    state_next = ST_DEN;
                end
            end
            ST_DEN: begin
                d_next     = prod_reg;
                state_next = ST_MAKE;
            end
            ST_MAKE: begin
                if (d_reg == '0) begin
                    rn_next    = '0;
                    rd_next    = {{(WIDTH-1){1'b0}}, 1'b1};
                    eq_next    = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    // Move the sign to the numerator, then seed Euclid.
                    n_next     = nn;
                    d_next     = dn;
                    ga_next    = mag_w(nn);
                    gb_next    = mag_w(dn);
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (gb_reg == '0) begin
                    state_next = ST_DIVN;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = ga_reg;
                    div_req.divisor  = gb_reg;
                    state_next       = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT: begin
                if (div_rsp.done) begin
                    ga_next    = gb_reg;
                    gb_next    = div_rsp.rem;
                    state_next = ST_GCD;
                end
            end
            ST_DIVN: begin
                div_req.start    = 1'b1;
                div_req.dividend = mag_w(n_reg);
                div_req.divisor  = ga_reg;
                state_next       = ST_DIVN_WAIT;
            end
            ST_DIVN_WAIT: begin
                if (div_rsp.done) begin
                    rn_next    = n_reg[WIDTH-1] ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                div_req.start    = 1'b1;
                div_req.dividend = mag_w(d_reg);
                div_req.divisor  = ga_reg;
                state_next       = ST_DIVD_WAIT;
            end
            ST_DIVD_WAIT: begin
                if (div_rsp.done) begin
                    rd_next    = d_reg[WIDTH-1] ? (~div_rsp.quot + 1'b1) : div_rsp.quot;
                    eq_next    = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    on_next    = to_out(rn_reg);
                    od_next    = to_out(rd_reg);
                    oe_next    = eq_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        prod_reg <= prod_next;
        x_reg    <= x_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        ga_reg   <= ga_next;
        gb_reg   <= gb_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        eq_reg   <= eq_next;
        on_reg   <= on_next;
        od_reg   <= od_next;
        oe_reg   <= oe_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = mv_reg;
    assign m_res_num  = on_reg;
    assign m_res_den  = od_reg;
    assign m_is_equal = oe_reg;

endmodule

FILE: rtl/core/rar_chk.sv
// ---------------------------------------------------------------------------
// rar_chk
// Port-level checks of the rational add/reduce unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rar_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_res_num,
    input logic signed [31:0] m_res_den,
    input logic               m_is_equal
);

    // A stalled result keeps its valid and its value.
    `ASSERT_PROP(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_res_num)
            && $stable(m_res_den) && $stable(m_is_equal),
        "stalled result changed")

    // Ready is low in the cycle after a request is accepted.
    `ASSERT_PROP(a_busy_after_accept, aclk, aresetn,
        s_valid && s_ready |=> !s_ready,
        "ready right after accept")

    // An equal result never carries a fraction.
    `ASSERT_NEVER(a_equal_no_frac, aclk, aresetn,
        m_valid && m_is_equal && (m_res_num != 0 || m_res_den != 0),
        "equal result with fraction")

endmodule

bind rational_add_reduce rar_chk u_rar_chk (.*);
